### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk, suspended while rst is high.
`define RRV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, with a plain boolean that must hold whenever the guard holds.
`define RRV_ASSERT_IMPLY(label, guard, cond, msg) \
  `RRV_ASSERT(label, (guard) |-> (cond), msg)

`endif

### rtl/core/rrv_pkg.sv
// Package with the types, constants and helpers of the reply validator.
package rrv_pkg;

  // Datagram framing.
  localparam int unsigned HEADER_BYTES     = 20;
  localparam int unsigned MAX_PACKET_BYTES = 4096;
  localparam int unsigned POS_W            = 13;
  localparam logic [POS_W-1:0] POS_MAX     = {POS_W{1'b1}};
  localparam logic [7:0] MA_TYPE           = 8'd80;

  // Configuration port.
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  localparam logic [1:0] REG_EXPECTED_ID    = 2'd0;
  localparam logic [1:0] REG_IS_AUTH        = 2'd1;
  localparam logic [1:0] REG_REQUIRE_MA     = 2'd2;

  // Reply codes that are recognized.
  localparam logic [7:0] CODE_ACCESS_ACCEPT   = 8'd2;
  localparam logic [7:0] CODE_ACCESS_REJECT   = 8'd3;
  localparam logic [7:0] CODE_ACCT_RESPONSE   = 8'd5;
  localparam logic [7:0] CODE_PASSWORD_ACK    = 8'd8;
  localparam logic [7:0] CODE_PASSWORD_REJECT = 8'd9;
  localparam logic [7:0] CODE_ACCESS_CHAL     = 8'd11;

  // Result status codes.
  localparam logic [2:0] ST_ACCEPT     = 3'd0;
  localparam logic [2:0] ST_REJECT     = 3'd1;
  localparam logic [2:0] ST_CHALLENGE  = 3'd2;
  localparam logic [2:0] ST_BAD_RESP   = 3'd3;
  localparam logic [2:0] ST_BAD_ID     = 3'd4;
  localparam logic [2:0] ST_MALFORMED  = 3'd5;
  localparam logic [2:0] ST_MA_MISSING = 3'd6;

  // Attribute walker phase.
  typedef enum logic [1:0] {
    PH_TYPE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2
  } attr_phase_t;

  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       last;
  } pkt_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  reply_code;
    logic [11:0] attr_bytes;
  } res_t;

  typedef struct packed {
    logic [7:0] expected_id;
    logic       is_auth_request;
    logic       require_ma_first;
  } cfg_t;

  // Maps a reply code to its final status when every check has passed.
  function automatic logic [2:0] map_code(input logic [7:0] code);
    logic [2:0] st;
    case (code)
      CODE_ACCESS_ACCEPT, CODE_ACCT_RESPONSE, CODE_PASSWORD_ACK: st = ST_ACCEPT;
      CODE_ACCESS_REJECT, CODE_PASSWORD_REJECT: st = ST_REJECT;
      CODE_ACCESS_CHAL: st = ST_CHALLENGE;
      default: st = ST_BAD_RESP;
    endcase
    return st;
  endfunction

endpackage

### rtl/core/rrv_cfg.sv
// Configuration registers behind the APB-style port.
module rrv_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrv_pkg::PADDR_W-1:0]   paddr,
  input  logic [rrv_pkg::PDATA_W-1:0]   pwdata,
  output logic [rrv_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output rrv_pkg::cfg_t                 cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes; addresses past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_id      <= 8'd0;
      cfg.is_auth_request  <= 1'b1;
      cfg.require_ma_first <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        rrv_pkg::REG_EXPECTED_ID: cfg.expected_id      <= pwdata[7:0];
        rrv_pkg::REG_IS_AUTH:     cfg.is_auth_request  <= pwdata[0];
        rrv_pkg::REG_REQUIRE_MA:  cfg.require_ma_first <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (reg_idx)
      rrv_pkg::REG_EXPECTED_ID: prdata = {24'd0, cfg.expected_id};
      rrv_pkg::REG_IS_AUTH:     prdata = {31'd0, cfg.is_auth_request};
      rrv_pkg::REG_REQUIRE_MA:  prdata = {31'd0, cfg.require_ma_first};
      default:                  prdata = '0;
    endcase
  end

endmodule

### rtl/core/rrv_parser.sv
// Per-datagram parser: header capture, attribute walk and final status.
module rrv_parser #(
  parameter int unsigned MAX_PACKET_BYTES = rrv_pkg::MAX_PACKET_BYTES
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  rrv_pkg::pkt_t item,
  input  rrv_pkg::cfg_t cfg,
  output rrv_pkg::res_t result
);

  localparam logic [rrv_pkg::POS_W-1:0] HDR_POS = rrv_pkg::POS_W'(rrv_pkg::HEADER_BYTES);
  localparam logic [15:0] HDR_LEN = 16'(rrv_pkg::HEADER_BYTES);
  localparam logic [15:0] MAX_LEN = 16'(MAX_PACKET_BYTES);

  // Per-datagram state.
  logic [rrv_pkg::POS_W-1:0] byte_pos;
  logic [7:0]                code_reg;
  logic [7:0]                id_reg;
  logic [15:0]               claimed_len;
  logic [7:0]                attr_left;
  rrv_pkg::attr_phase_t      attr_phase;
  logic [7:0]                first_attr_type;
  logic                      walk_error;

  logic [rrv_pkg::POS_W-1:0] byte_pos_next;
  logic [7:0]                code_reg_next;
  logic [7:0]                id_reg_next;
  logic [15:0]               claimed_len_next;
  logic [7:0]                attr_left_next;
  rrv_pkg::attr_phase_t      attr_phase_next;
  logic [7:0]                first_attr_type_next;
  logic                      walk_error_next;

  logic        in_area;
  logic [16:0] len_reach;
  logic [16:0] len_limit;
  logic        in_range;
  logic [15:0] attr_area;

  // Bytes inside the claimed area past the header are walked.
  assign in_area = (byte_pos >= HDR_POS) &&
                   ({{(16-rrv_pkg::POS_W){1'b0}}, byte_pos} < claimed_len);

  // A length byte overruns when pos + len exceeds claimed_len + 1.
  assign len_reach = {9'd0, item.pkt_byte} + {{(17-rrv_pkg::POS_W){1'b0}}, byte_pos};
  assign len_limit = {1'b0, claimed_len} + 17'd1;

  // Next state: header fields, byte counter and attribute walker.
  always_comb begin
    code_reg_next        = code_reg;
    id_reg_next          = id_reg;
    claimed_len_next     = claimed_len;
    attr_left_next       = attr_left;
    attr_phase_next      = attr_phase;
    first_attr_type_next = first_attr_type;
    walk_error_next      = walk_error;
    byte_pos_next = (byte_pos != rrv_pkg::POS_MAX) ? byte_pos + 1'b1 : byte_pos;

    if (byte_pos == rrv_pkg::POS_W'(0)) begin
      code_reg_next = item.pkt_byte;
    end else if (byte_pos == rrv_pkg::POS_W'(1)) begin
      id_reg_next = item.pkt_byte;
    end else if (byte_pos == rrv_pkg::POS_W'(2)) begin
      claimed_len_next = {item.pkt_byte, 8'd0};
    end else if (byte_pos == rrv_pkg::POS_W'(3)) begin
      claimed_len_next = {claimed_len[15:8], item.pkt_byte};
    end else if (in_area && !walk_error) begin
      case (attr_phase)
        rrv_pkg::PH_TYPE: begin
          if (byte_pos == HDR_POS) first_attr_type_next = item.pkt_byte;
          if (item.pkt_byte == 8'd0) walk_error_next = 1'b1;
          attr_phase_next = rrv_pkg::PH_LEN;
        end
        rrv_pkg::PH_LEN: begin
          if (item.pkt_byte < 8'd2 || len_reach > len_limit) begin
            walk_error_next = 1'b1;
          end else begin
            attr_left_next  = item.pkt_byte - 8'd2;
            attr_phase_next = (item.pkt_byte == 8'd2) ? rrv_pkg::PH_TYPE : rrv_pkg::PH_VALUE;
          end
        end
        default: begin
          attr_left_next = attr_left - 8'd1;
          if (attr_left == 8'd1) attr_phase_next = rrv_pkg::PH_TYPE;
        end
      endcase
    end
  end

  assign in_range  = (claimed_len_next >= HDR_LEN) && (claimed_len_next <= MAX_LEN);
  assign attr_area = claimed_len_next - HDR_LEN;

  // Result for a datagram that ends with this byte, checks in priority order.
  always_comb begin
    result.reply_code = code_reg_next;
    result.attr_bytes = in_range ? attr_area[11:0] : 12'd0;
    if (byte_pos_next < HDR_POS ||
        {{(16-rrv_pkg::POS_W){1'b0}}, byte_pos_next} < claimed_len_next) begin
      result.status = rrv_pkg::ST_MALFORMED;
    end else if (!in_range) begin
      result.status = rrv_pkg::ST_BAD_RESP;
    end else if (id_reg_next != cfg.expected_id) begin
      result.status = rrv_pkg::ST_BAD_ID;
    end else if (walk_error_next || attr_phase_next != rrv_pkg::PH_TYPE) begin
      result.status = rrv_pkg::ST_MALFORMED;
    end else if (cfg.is_auth_request && cfg.require_ma_first &&
                 (attr_area == 16'd0 || first_attr_type_next != rrv_pkg::MA_TYPE)) begin
      result.status = rrv_pkg::ST_MA_MISSING;
    end else begin
      result.status = rrv_pkg::map_code(code_reg_next);
    end
  end

  // State update; the last byte returns everything to its reset values.
  always_ff @(posedge clk) begin
    if (rst || (step && item.last)) begin
      byte_pos        <= '0;
      code_reg        <= 8'd0;
      id_reg          <= 8'd0;
      claimed_len     <= 16'd0;
      attr_left       <= 8'd0;
      attr_phase      <= rrv_pkg::PH_TYPE;
      first_attr_type <= 8'd0;
      walk_error      <= 1'b0;
    end else if (step) begin
      byte_pos        <= byte_pos_next;
      code_reg        <= code_reg_next;
      id_reg          <= id_reg_next;
      claimed_len     <= claimed_len_next;
      attr_left       <= attr_left_next;
      attr_phase      <= attr_phase_next;
      first_attr_type <= first_attr_type_next;
      walk_error      <= walk_error_next;
    end
  end

endmodule

### rtl/core/radius_reply_validator.sv
// Top level of the RADIUS reply validator: channel registers and assembly.
//
// Usage: the received reply datagram enters on the pkt channel, one byte per
// transfer, with pkt.last set on its final byte. Bytes past the claimed length
// are ignored. For each datagram exactly one result transfer leaves on the res
// channel, carrying the status, the reply code and the attribute area size.
// Configuration (expected id, request kind, Message-Authenticator rule) is
// written through the APB-style port while no datagram is in flight.
// Throughput: one byte per cycle, except while a final byte waits on a stalled
// result; the parse state updates in a single pass between the input register
// and the result register. The final byte passes the input register, then its
// result is loaded into the result register.
// Reset (rst, synchronous) empties both registers, clears the parse state and
// loads the configuration defaults. While the receiver stalls a waiting result,
// non-final bytes keep flowing; a final byte waits in the input register, and
// pkt_stall rises only once that register is occupied and blocked.
`include "assert_macros.svh"

module radius_reply_validator #(
  parameter int unsigned MAX_PACKET_BYTES = rrv_pkg::MAX_PACKET_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pkt_valid,
  output logic                          pkt_stall,
  input  rrv_pkg::pkt_t                 pkt,
  output logic                          res_valid,
  input  logic                          res_stall,
  output rrv_pkg::res_t                 res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrv_pkg::PADDR_W-1:0]   paddr,
  input  logic [rrv_pkg::PDATA_W-1:0]   pwdata,
  output logic [rrv_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  rrv_pkg::cfg_t cfg;
  rrv_pkg::pkt_t item;
  rrv_pkg::res_t result;
  logic          item_valid;
  logic          res_free;
  logic          advance;
  logic          res_load;

  rrv_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // A byte moves on unless it finishes a datagram and the result slot is full.
  assign res_free  = !res_valid || !res_stall;
  assign advance   = item_valid && (!item.last || res_free);
  assign res_load  = advance && item.last;
  assign pkt_stall = item_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!pkt_stall) begin
      item_valid <= pkt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!pkt_stall) begin
      item <= pkt;
    end
  end

  rrv_parser #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= result;
    end
  end

  // A new result is never produced over one the receiver still holds.
  `RRV_ASSERT_IMPLY(a_no_overwrite, res_valid && res_stall, !res_load,
                    "result overwritten while stalled")

  // An accept status only comes from a code that maps to accept.
  `RRV_ASSERT_IMPLY(a_accept_code, res_valid && res.status == rrv_pkg::ST_ACCEPT,
                    res.reply_code == rrv_pkg::CODE_ACCESS_ACCEPT ||
                    res.reply_code == rrv_pkg::CODE_ACCT_RESPONSE ||
                    res.reply_code == rrv_pkg::CODE_PASSWORD_ACK,
                    "accept status with a non-accept code")

  // A final byte that finds the result slot free is taken at once.
  `RRV_ASSERT_IMPLY(a_last_moves, item_valid && item.last && res_free, !pkt_stall,
                    "final byte held with the result slot free")

endmodule
